FILE: src/timestamped_event_fifo_macros.svh
// Assertion macros for the timestamped event queue.
// Used by the port checker; relies on signals named clock and reset in scope.
`ifndef TIMESTAMPED_EVENT_FIFO_MACROS_SVH
`define TIMESTAMPED_EVENT_FIFO_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TSEF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TSEF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/tsef_pkg.sv
// Shared types and constants of the timestamped event queue.
// No dependencies; used by every module of the block.
package tsef_pkg;

   // Default sizes handed to the top level parameters.
   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int TYPE_COUNT_DEF  = 16;

   // Field widths fixed by the item format.
   localparam int TYPE_W  = 4;
   localparam int WORD_W  = 32;
   localparam int CBEF_W  = 6;
   localparam int OP_W    = 2;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 112;
   localparam int RSP_PAD_W   = RSP_TDATA_W - (TYPE_W + 3 * WORD_W + CBEF_W);

   // Operation codes carried in the request tuser.
   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_QUERY   = 2'd2,
      OP_CLEAR   = 2'd3
   } tsef_op_type;

   // Decoded operation of one accepted item.
   typedef struct packed {
      logic enq;
      logic deq;
      logic stat;
      logic clr;
   } tsef_cmd_type;

   // Queue status seen by the counter unit.
   typedef struct packed {
      logic full;
      logic empty;
   } tsef_qstat_type;

   // One stored queue entry.
   typedef struct packed {
      logic [WORD_W-1:0] stamp;
      logic [WORD_W-1:0] aux;
      logic [TYPE_W-1:0] etype;
   } tsef_entry_type;

endpackage

FILE: src/timestamped_event_fifo.sv
// Top level of the timestamped event queue: stream ports, stage control and
// output register. Depends on tsef_pkg, tsef_queue and tsef_stats.
//
// Each request item carries an operation in tuser (enqueue, dequeue,
// statistics query, clear) and returns exactly one response item, in order.
// The block takes one item per clock cycle unless the output stalls; a request
// passes the first stage register, then the output register. That rate is set
// by the entry store and the counter memory, each read once per item through a
// registered port, with the counter increment written back as the item leaves
// the first stage and forwarded to a request that reads the same counter. An
// output register lets a new request be accepted while an earlier response
// waits. The counters are cleared at reset through per-type valid bits, so no
// clearing pass is run. count_before carries the low six bits of the occupancy.
module timestamped_event_fifo #(
   parameter int QUEUE_DEPTH = tsef_pkg::QUEUE_DEPTH_DEF,
   parameter int TYPE_COUNT  = tsef_pkg::TYPE_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: event_type[3:0], aux_data[35:4], now_time[67:36], zero pad.
   input  logic [tsef_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: op[1:0].
   input  logic [tsef_pkg::OP_W-1:0]        req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: out_type[3:0], out_aux[35:4], out_time[67:36], count_before[73:68],
   // stat_count[105:74], zero pad.
   output logic [tsef_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: overflow[0].
   output logic                             rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);

   tsef_pkg::tsef_cmd_type   cmd;
   tsef_pkg::tsef_qstat_type qstat;

   logic [tsef_pkg::TYPE_W-1:0] event_type;
   logic [tsef_pkg::WORD_W-1:0] aux_data;
   logic [tsef_pkg::WORD_W-1:0] now_time;

   logic [tsef_pkg::TYPE_W-1:0] deq_type;
   logic [tsef_pkg::WORD_W-1:0] deq_aux;
   logic [tsef_pkg::WORD_W-1:0] deq_time;
   logic [tsef_pkg::CBEF_W-1:0] count_before;
   logic [tsef_pkg::WORD_W-1:0] stat_count;
   logic                        overflow;

   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [tsef_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic                             rsp_user_ff;

   logic accept;
   logic s1_move;

   // Request payload fields.
   assign event_type = req_tdata[3:0];
   assign aux_data   = req_tdata[35:4];
   assign now_time   = req_tdata[67:36];

   // Operation decode.
   always_comb begin
      cmd = '0;
      case (tsef_pkg::tsef_op_type'(req_tuser))
         tsef_pkg::OP_ENQUEUE: begin
            cmd.enq = 1'b1;
         end
         tsef_pkg::OP_DEQUEUE: begin
            cmd.deq = 1'b1;
         end
         tsef_pkg::OP_QUERY: begin
            cmd.stat = 1'b1;
         end
         tsef_pkg::OP_CLEAR: begin
            cmd.clr = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Stage control: the first stage moves on when the output register is free.
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   tsef_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (cmd),
      .event_type   (event_type),
      .aux_data     (aux_data),
      .now_time     (now_time),
      .status       (qstat),
      .deq_type     (deq_type),
      .deq_aux      (deq_aux),
      .deq_time     (deq_time),
      .count_before (count_before),
      .overflow     (overflow)
   );

   tsef_stats #(
      .TYPE_COUNT (TYPE_COUNT)
   ) u_stats (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .commit     (s1_move),
      .cmd        (cmd),
      .status     (qstat),
      .event_type (event_type),
      .stat_count (stat_count)
   );

   // Output register, loaded when the first stage hands over its item.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= {{tsef_pkg::RSP_PAD_W{1'b0}}, stat_count, count_before,
                         deq_time, deq_aux, deq_type};
         rsp_user_ff <= overflow;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: src/tsef_queue.sv
// Circular entry store with head pointer and occupancy for the event queue.
// Depends on tsef_pkg for the command, status and entry types.
module tsef_queue #(
   parameter int QUEUE_DEPTH = tsef_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  tsef_pkg::tsef_cmd_type      cmd,
   input  logic [tsef_pkg::TYPE_W-1:0] event_type,
   input  logic [tsef_pkg::WORD_W-1:0] aux_data,
   input  logic [tsef_pkg::WORD_W-1:0] now_time,
   output tsef_pkg::tsef_qstat_type    status,
   output logic [tsef_pkg::TYPE_W-1:0] deq_type,
   output logic [tsef_pkg::WORD_W-1:0] deq_aux,
   output logic [tsef_pkg::WORD_W-1:0] deq_time,
   output logic [tsef_pkg::CBEF_W-1:0] count_before,
   output logic                        overflow
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = PTR_W + 2;

   tsef_pkg::tsef_entry_type entry_mem [QUEUE_DEPTH];
   tsef_pkg::tsef_entry_type rd_entry_ff;
   tsef_pkg::tsef_entry_type wr_entry;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic             hit_ff, hit_in;
   logic             ovf_ff, ovf_in;
   logic [tsef_pkg::CBEF_W-1:0] cbef_ff;

   logic [SUM_W-1:0] tail_sum;
   logic [PTR_W-1:0] tail_slot;
   logic [PTR_W-1:0] head_step;
   logic             do_push;

   // Full and empty come straight from the occupancy.
   assign status.full  = (occ_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (occ_ff == '0);

   // Tail slot is head plus occupancy, folded once into the queue range.
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(occ_ff);
   assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
   assign head_step = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign do_push = accept && cmd.enq && !status.full;

   assign wr_entry.stamp = now_time;
   assign wr_entry.aux   = aux_data;
   assign wr_entry.etype = event_type;

   // Pointer and occupancy update for the accepted item.
   always_comb begin
      head_in = head_ff;
      occ_in  = occ_ff;
      hit_in  = hit_ff;
      ovf_in  = ovf_ff;
      if (accept) begin
         hit_in = cmd.deq && !status.empty;
         ovf_in = cmd.enq && status.full;
         if (do_push) begin
            occ_in = occ_ff + 1'b1;
         end
         if (cmd.deq && !status.empty) begin
            head_in = head_step;
            occ_in  = occ_ff - 1'b1;
         end
         if (cmd.clr) begin
            head_in = '0;
            occ_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         occ_ff  <= '0;
         hit_ff  <= 1'b0;
         ovf_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         occ_ff  <= occ_in;
         hit_ff  <= hit_in;
         ovf_ff  <= ovf_in;
      end
   end

   // Entry store: write at the tail on a push, read the oldest entry on every item.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_mem[tail_slot] <= wr_entry;
      end
      if (accept) begin
         rd_entry_ff <= entry_mem[head_ff];
         cbef_ff     <= tsef_pkg::CBEF_W'(occ_ff);
      end
   end

   // Dequeue fields read as zero unless the item took an entry.
   assign deq_type     = hit_ff ? rd_entry_ff.etype : '0;
   assign deq_aux      = hit_ff ? rd_entry_ff.aux   : '0;
   assign deq_time     = hit_ff ? rd_entry_ff.stamp : '0;
   assign count_before = hit_ff ? cbef_ff           : '0;
   assign overflow     = ovf_ff;

endmodule

FILE: src/tsef_stats.sv
// Per-type push counters and running total of the event queue.
// Depends on tsef_pkg for the command and queue status types.
module tsef_stats #(
   parameter int TYPE_COUNT = tsef_pkg::TYPE_COUNT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        commit,
   input  tsef_pkg::tsef_cmd_type      cmd,
   input  tsef_pkg::tsef_qstat_type    status,
   input  logic [tsef_pkg::TYPE_W-1:0] event_type,
   output logic [tsef_pkg::WORD_W-1:0] stat_count
);

   localparam int ADDR_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
   localparam int EXT_W  = (ADDR_W + 1 > tsef_pkg::TYPE_W) ? ADDR_W + 1 : tsef_pkg::TYPE_W;

   logic [tsef_pkg::WORD_W-1:0] cnt_mem [TYPE_COUNT];
   logic [TYPE_COUNT-1:0]       valid_ff, valid_in;

   logic [EXT_W-1:0]  ev_ext;
   logic [ADDR_W-1:0] rd_addr;
   logic              in_range;
   logic              counted;

   logic [tsef_pkg::WORD_W-1:0] total_ff, total_in;
   logic [tsef_pkg::WORD_W-1:0] total_q_ff;
   logic [tsef_pkg::WORD_W-1:0] rd_q_ff;
   logic                        rd_vld_ff;
   logic                        fwd_ff;
   logic [tsef_pkg::WORD_W-1:0] fwd_data_ff;
   logic                        pend_ff, pend_in;
   logic [ADDR_W-1:0]           wr_addr_ff;
   logic                        sel_total_ff;
   logic                        sel_count_ff;

   logic [tsef_pkg::WORD_W-1:0] raw_count;
   logic [tsef_pkg::WORD_W-1:0] wr_data;
   logic                        wr_en;

   // Range check on the event type against the configured number of types.
   assign ev_ext   = EXT_W'(event_type);
   assign in_range = (ev_ext < EXT_W'(TYPE_COUNT));
   assign rd_addr  = ev_ext[ADDR_W-1:0];
   assign counted  = accept && cmd.enq && !status.full;

   // Counter value of the item in the first stage, with write forwarding.
   assign raw_count = fwd_ff ? fwd_data_ff : (rd_vld_ff ? rd_q_ff : '0);
   assign wr_data   = raw_count + 1'b1;
   assign wr_en     = commit && pend_ff;

   // Control updates: total, pending increment and valid bits.
   always_comb begin
      total_in = total_ff;
      pend_in  = pend_ff;
      valid_in = valid_ff;
      if (counted) begin
         total_in = total_ff + 1'b1;
      end
      if (accept) begin
         pend_in = counted && in_range;
      end
      if (wr_en) begin
         valid_in[wr_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         pend_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         total_ff <= total_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   // Counter memory: write back the increment, read the item's counter.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[wr_addr_ff] <= wr_data;
      end
      if (accept) begin
         rd_q_ff      <= cnt_mem[rd_addr];
         rd_vld_ff    <= valid_ff[rd_addr];
         fwd_ff       <= wr_en && (wr_addr_ff == rd_addr);
         fwd_data_ff  <= wr_data;
         wr_addr_ff   <= rd_addr;
         total_q_ff   <= total_ff;
         sel_total_ff <= cmd.stat && (event_type == '0);
         sel_count_ff <= cmd.stat && (event_type != '0) && in_range;
      end
   end

   // Query answer: running total for type zero, else the type's counter, or zero for a type out of range.
   assign stat_count = sel_total_ff ? total_q_ff : (sel_count_ff ? raw_count : '0);

endmodule

FILE: src/tsef_checker.sv
// Port checker for the timestamped event queue, bound to the top level.
// Depends on tsef_pkg and the assertion macros header.
`include "timestamped_event_fifo_macros.svh"

module tsef_checker (
   input logic                             clock,
   input logic                             reset,
   input logic [tsef_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);

   logic [tsef_pkg::RSP_TDATA_W:0] rsp_word;
   logic [tsef_pkg::WORD_W-1:0]    stat_field;
   logic [73:0]                    low_field;
   logic                           stalled;
   logic                           stat_seen;
   logic                           held_seen;

   // Response fields and conditions as the assertions see them.
   assign rsp_word   = {rsp_tuser, rsp_tdata};
   assign stat_field = rsp_tdata[105:74];
   assign low_field  = rsp_tdata[73:0];
   assign stalled    = rsp_tvalid && !rsp_tready;
   assign stat_seen  = rsp_tvalid && (stat_field != '0);
   assign held_seen  = rsp_tvalid && (rsp_tdata[73:68] != '0);

   // A stalled response item keeps its payload.
   `TSEF_ASSERT_NXT(a_rsp_hold, stalled, rsp_tvalid && $stable(rsp_word), "stalled item changed")

   // A dropped enqueue reports nothing but the overflow flag.
   `TSEF_ASSERT_IMP(a_ovf_quiet, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "overflow item has data")

   // A query answer never comes with dequeue fields.
   `TSEF_ASSERT_IMP(a_stat_alone, stat_seen, (low_field == '0) && !rsp_tuser, "query answer mixed")

   // A dequeue that found entries carries no query answer.
   `TSEF_ASSERT_IMP(a_deq_alone, held_seen, (stat_field == '0) && !rsp_tuser, "dequeue item mixed")

endmodule

bind timestamped_event_fifo tsef_checker u_checker (.*);
